// ----- design/ege_pkg.sv -----
// ege_pkg: shared types and constants for the elgamal encryption unit
// holds the microcode word layout, operand codes and register indexes
// no dependencies
`default_nettype none

package ege_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   localparam csr_index_type CSR_MODULUS    = 2'd0;
   localparam csr_index_type CSR_GENERATOR  = 2'd1;
   localparam csr_index_type CSR_PUBLIC_KEY = 2'd2;

   // field widths fixed by the interface
   localparam int DATA_WIDTH = 32;
   localparam int EXP_WIDTH  = 32;

   // datapath register / operand codes
   typedef logic [2:0] reg_sel_type;
   localparam reg_sel_type SEL_ONE = 3'd0;
   localparam reg_sel_type SEL_GB  = 3'd1;   // generator base / square
   localparam reg_sel_type SEL_KB  = 3'd2;   // key base / square
   localparam reg_sel_type SEL_GA  = 3'd3;   // generator power
   localparam reg_sel_type SEL_KA  = 3'd4;   // key power
   localparam reg_sel_type SEL_DG  = 3'd5;   // digit, later second part

   // microcode word kinds
   typedef logic [2:0] uop_kind_type;
   localparam uop_kind_type UOP_MUL  = 3'd0;  // dst = a * b mod m
   localparam uop_kind_type UOP_BRZ  = 3'd1;  // branch if exponent is zero
   localparam uop_kind_type UOP_BRC  = 3'd2;  // branch if exponent lsb clear
   localparam uop_kind_type UOP_JMP  = 3'd3;  // unconditional branch
   localparam uop_kind_type UOP_FIN  = 3'd4;  // deliver result, go idle

   localparam int PC_WIDTH = 4;
   typedef logic [PC_WIDTH-1:0] pc_type;

   typedef struct packed {
      uop_kind_type kind;
      reg_sel_type  src_a;
      reg_sel_type  src_b;
      reg_sel_type  dst;
      logic         shift_exp;
      pc_type       target;
   } ucode_word_type;

   // control from sequencer to datapath
   typedef struct packed {
      logic        load;
      logic        write;
      reg_sel_type dst;
      reg_sel_type src_a;
      reg_sel_type src_b;
      logic        shift_exp;
   } dp_ctrl_type;

   // status from datapath to sequencer
   typedef struct packed {
      logic exp_zero;
      logic exp_lsb;
   } dp_status_type;

   function automatic ucode_word_type uop(input uop_kind_type kind,
                                          input reg_sel_type a,
                                          input reg_sel_type b,
                                          input reg_sel_type d,
                                          input logic sh,
                                          input pc_type tgt);
      ucode_word_type w;
      w.kind      = kind;
      w.src_a     = a;
      w.src_b     = b;
      w.dst       = d;
      w.shift_exp = sh;
      w.target    = tgt;
      return w;
   endfunction

   // control program: reduce operands, square-and-multiply loop, final product
   function automatic ucode_word_type ucode_rom(input pc_type pc);
      ucode_word_type w;
      case (pc)
         4'd0:    w = uop(UOP_MUL, SEL_ONE, SEL_GB, SEL_GB, 1'b0, 4'd0);
         4'd1:    w = uop(UOP_MUL, SEL_ONE, SEL_KB, SEL_KB, 1'b0, 4'd0);
         4'd2:    w = uop(UOP_MUL, SEL_ONE, SEL_DG, SEL_DG, 1'b0, 4'd0);
         4'd3:    w = uop(UOP_BRZ, SEL_ONE, SEL_ONE, SEL_ONE, 1'b0, 4'd10);
         4'd4:    w = uop(UOP_BRC, SEL_ONE, SEL_ONE, SEL_ONE, 1'b0, 4'd7);
         4'd5:    w = uop(UOP_MUL, SEL_GA, SEL_GB, SEL_GA, 1'b0, 4'd0);
         4'd6:    w = uop(UOP_MUL, SEL_KA, SEL_KB, SEL_KA, 1'b0, 4'd0);
         4'd7:    w = uop(UOP_MUL, SEL_GB, SEL_GB, SEL_GB, 1'b0, 4'd0);
         4'd8:    w = uop(UOP_MUL, SEL_KB, SEL_KB, SEL_KB, 1'b1, 4'd0);
         4'd9:    w = uop(UOP_JMP, SEL_ONE, SEL_ONE, SEL_ONE, 1'b0, 4'd3);
         4'd10:   w = uop(UOP_MUL, SEL_KA, SEL_DG, SEL_DG, 1'b0, 4'd0);
         default: w = uop(UOP_FIN, SEL_ONE, SEL_ONE, SEL_ONE, 1'b0, 4'd0);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- design/elgamal_encrypt_unit.sv -----
// elgamal_encrypt_unit: top level of the elgamal encryption block
// holds the configuration registers and wires sequencer, datapath, multiplier
// depends on ege_pkg, ege_modmul, ege_datapath, ege_sequencer
//
// usage
//  - configuration: csr_we writes csr_wdata into the register csr_index
//    selects (modulus, generator, public key); write only while busy is low
//  - request: a transfer happens at a clock edge with start high, busy low;
//    req_message_digit and req_ephemeral_exponent are captured then
//  - response: rsp_valid is high for exactly one cycle with rsp_cipher_first
//    (g^b mod p) and rsp_cipher_second (k^b * digit mod p); the receiver
//    cannot stall, so the result is simply presented and dropped
//  - one shared bit-serial modular multiplier computes every product; an item
//    takes four products to reduce the operands and finish, plus, for each
//    exponent bit up to the highest set bit, 4 products for a set bit and 2
//    for a clear one
//  - a new request is taken in the cycle the response strobe is up
//  - reset: modulus returns to 2, generator and public key to 0, the
//    sequencer goes idle and no response is pending
`default_nettype none

module elgamal_encrypt_unit
   import ege_pkg::*;
#(
   parameter int MOD_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [DATA_WIDTH-1:0] req_message_digit,
   input  wire logic [EXP_WIDTH-1:0]  req_ephemeral_exponent,
   output logic                       rsp_valid,
   output logic [DATA_WIDTH-1:0]      rsp_cipher_first,
   output logic [DATA_WIDTH-1:0]      rsp_cipher_second,
   input  wire logic                  csr_we,
   input  wire csr_index_type         csr_index,
   input  wire logic [DATA_WIDTH-1:0] csr_wdata
);

   localparam int W = MOD_WIDTH;

   logic [W-1:0]  modulus_ff, generator_ff, public_key_ff;
   logic [W:0]    mod_eff;
   logic [W-1:0]  one_val;
   logic          mul_start, mul_done;
   logic [W-1:0]  mul_a, mul_b, mul_result;
   logic [W-1:0]  first_val, second_val;
   dp_ctrl_type   ctrl;
   dp_status_type status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= W'(2);
         generator_ff  <= '0;
         public_key_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODULUS:    modulus_ff    <= csr_wdata[W-1:0];
            CSR_GENERATOR:  generator_ff  <= csr_wdata[W-1:0];
            CSR_PUBLIC_KEY: public_key_ff <= csr_wdata[W-1:0];
            default: ;
         endcase
      end
   end

   // zero modulus stands for 2^W; one mod m is zero only for m of one
   assign mod_eff = (modulus_ff == '0) ? {1'b1, {W{1'b0}}} : {1'b0, modulus_ff};
   assign one_val = (mod_eff == (W+1)'(1)) ? '0 : W'(1);

   ege_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .mul_done  (mul_done),
      .busy      (busy),
      .mul_start (mul_start),
      .ctrl      (ctrl),
      .rsp_valid (rsp_valid)
   );

   ege_datapath #(.W(W)) u_datapath (
      .clock      (clock),
      .ctrl       (ctrl),
      .one_val    (one_val),
      .gen_val    (generator_ff),
      .key_val    (public_key_ff),
      .digit_val  (req_message_digit[W-1:0]),
      .exp_val    (req_ephemeral_exponent),
      .mul_result (mul_result),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .status     (status),
      .first_out  (first_val),
      .second_out (second_val)
   );

   ege_modmul #(.W(W)) u_modmul (
      .clock      (clock),
      .reset      (reset),
      .mul_start  (mul_start),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .mul_m      (mod_eff),
      .mul_done   (mul_done),
      .mul_result (mul_result)
   );

   assign rsp_cipher_first  = DATA_WIDTH'(first_val);
   assign rsp_cipher_second = DATA_WIDTH'(second_val);

endmodule

`default_nettype wire

// ----- design/ege_modmul.sv -----
// ege_modmul: bit-serial interleaved modular multiplier, one bit of b per cycle
// result = a * b mod m, with a below m and b any value of the operand width
// depends on ege_pkg
`default_nettype none

module ege_modmul
   import ege_pkg::*;
#(
   parameter int W = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         mul_start,
   input  wire logic [W-1:0] mul_a,
   input  wire logic [W-1:0] mul_b,
   input  wire logic [W:0]   mul_m,
   output logic              mul_done,
   output logic [W-1:0]      mul_result
);

   localparam int CW = $clog2(W);

   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  a_ff;
   logic [W-1:0]  b_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;

   logic [W+1:0] m_ext, t1, t1r, t2, t2r;

   // one step: r = 2r mod m, then r = r + a*bit mod m
   always_comb begin
      m_ext = {1'b0, mul_m};
      t1    = {1'b0, r_ff, 1'b0};
      t1r   = (t1 >= m_ext) ? (t1 - m_ext) : t1;
      t2    = t1r + (b_ff[W-1] ? {2'b00, a_ff} : {(W+2){1'b0}});
      t2r   = (t2 >= m_ext) ? (t2 - m_ext) : t2;
      r_in  = t2r[W-1:0];
   end

   // control of the bit loop
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mul_start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   // operand and partial result registers
   always_ff @(posedge clock) begin
      if (mul_start) begin
         r_ff <= '0;
         a_ff <= mul_a;
         b_ff <= mul_b;
      end else if (busy_ff) begin
         r_ff <= r_in;
         b_ff <= {b_ff[W-2:0], 1'b0};
      end
   end

   assign mul_done   = done_ff;
   assign mul_result = r_ff;

endmodule

`default_nettype wire

// ----- design/ege_datapath.sv -----
// ege_datapath: operand registers, exponent shifter and operand selection
// driven by the sequencer control struct; feeds the modular multiplier
// depends on ege_pkg
`default_nettype none

module ege_datapath
   import ege_pkg::*;
#(
   parameter int W = 32
) (
   input  wire logic                 clock,
   input  wire dp_ctrl_type          ctrl,
   input  wire logic [W-1:0]         one_val,
   input  wire logic [W-1:0]         gen_val,
   input  wire logic [W-1:0]         key_val,
   input  wire logic [W-1:0]         digit_val,
   input  wire logic [EXP_WIDTH-1:0] exp_val,
   input  wire logic [W-1:0]         mul_result,
   output logic [W-1:0]              mul_a,
   output logic [W-1:0]              mul_b,
   output dp_status_type             status,
   output logic [W-1:0]              first_out,
   output logic [W-1:0]              second_out
);

   logic [W-1:0]         gb_ff, kb_ff, ga_ff, ka_ff, dg_ff;
   logic [EXP_WIDTH-1:0] exp_ff;

   function automatic logic [W-1:0] pick(input reg_sel_type sel,
                                         input logic [W-1:0] one_v,
                                         input logic [W-1:0] gb,
                                         input logic [W-1:0] kb,
                                         input logic [W-1:0] ga,
                                         input logic [W-1:0] ka,
                                         input logic [W-1:0] dg);
      logic [W-1:0] v;
      case (sel)
         SEL_ONE: v = one_v;
         SEL_GB:  v = gb;
         SEL_KB:  v = kb;
         SEL_GA:  v = ga;
         SEL_KA:  v = ka;
         SEL_DG:  v = dg;
         default: v = one_v;
      endcase
      return v;
   endfunction

   // operand selection for the multiplier
   assign mul_a = pick(ctrl.src_a, one_val, gb_ff, kb_ff, ga_ff, ka_ff, dg_ff);
   assign mul_b = pick(ctrl.src_b, one_val, gb_ff, kb_ff, ga_ff, ka_ff, dg_ff);

   // register file: load on item transfer, write back on multiplier done
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         gb_ff  <= gen_val;
         kb_ff  <= key_val;
         dg_ff  <= digit_val;
         ga_ff  <= one_val;
         ka_ff  <= one_val;
         exp_ff <= exp_val;
      end else if (ctrl.write) begin
         case (ctrl.dst)
            SEL_GB:  gb_ff <= mul_result;
            SEL_KB:  kb_ff <= mul_result;
            SEL_GA:  ga_ff <= mul_result;
            SEL_KA:  ka_ff <= mul_result;
            SEL_DG:  dg_ff <= mul_result;
            default: ;
         endcase
         if (ctrl.shift_exp) begin
            exp_ff <= {1'b0, exp_ff[EXP_WIDTH-1:1]};
         end
      end
   end

   assign status.exp_zero = (exp_ff == '0);
   assign status.exp_lsb  = exp_ff[0];
   assign first_out       = ga_ff;
   assign second_out      = dg_ff;

endmodule

`default_nettype wire

// ----- design/ege_sequencer.sv -----
// ege_sequencer: microcode step counter, control rom decode and branching
// issues multiplies, waits for completion, raises the result strobe
// depends on ege_pkg
`default_nettype none

module ege_sequencer
   import ege_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire dp_status_type status,
   input  wire logic          mul_done,
   output logic               busy,
   output logic               mul_start,
   output dp_ctrl_type        ctrl,
   output logic               rsp_valid
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   logic [1:0]     state_ff, state_in;
   pc_type         pc_ff, pc_in;
   logic           valid_ff, valid_in;
   ucode_word_type word;

   assign word = ucode_rom(pc_ff);

   // next step and control decode
   always_comb begin
      state_in       = state_ff;
      pc_in          = pc_ff;
      valid_in       = 1'b0;
      mul_start      = 1'b0;
      ctrl.load      = 1'b0;
      ctrl.write     = 1'b0;
      ctrl.dst       = word.dst;
      ctrl.src_a     = word.src_a;
      ctrl.src_b     = word.src_b;
      ctrl.shift_exp = word.shift_exp;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               pc_in     = '0;
               state_in  = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            case (word.kind)
               UOP_MUL: begin
                  mul_start = 1'b1;
                  state_in  = ST_WAIT;
               end
               UOP_BRZ: pc_in = status.exp_zero ? word.target : pc_ff + 1'b1;
               UOP_BRC: pc_in = status.exp_lsb ? pc_ff + 1'b1 : word.target;
               UOP_JMP: pc_in = word.target;
               default: begin
                  valid_in = 1'b1;
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_WAIT: begin
            if (mul_done) begin
               ctrl.write = 1'b1;
               pc_in      = pc_ff + 1'b1;
               state_in   = ST_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking testbench for the elgamal encryption unit
// predicts both ciphertext parts with its own square-and-multiply model
// depends on ege_pkg and the elgamal_encrypt_unit design files

module tb_top;
   import ege_pkg::*;

   localparam int OPERAND_BITS = 32;
   localparam int MAX_GAP = 40;
   localparam int RANDOM_ITEMS = 560;
   // one modular product on the shared multiplier, and the slowest item plus a gap
   localparam int PRODUCT_CYCLES = OPERAND_BITS + 2;
   localparam int ITEM_WORST_CYCLES = 2 + 4 * PRODUCT_CYCLES
                                    + EXP_WIDTH * (3 + 4 * PRODUCT_CYCLES) + MAX_GAP;
   localparam int CYCLE_LIMIT = 4 * (RANDOM_ITEMS + 40) * ITEM_WORST_CYCLES;
   // index with no register behind it
   localparam csr_index_type CSR_UNUSED = 2'd3;

   typedef struct {
      bit [DATA_WIDTH-1:0] first;
      bit [DATA_WIDTH-1:0] second;
   } cipher_pair_type;

   // mirror of the configuration and the queue of ciphertexts still owed
   class cipher_scoreboard;
      bit [DATA_WIDTH-1:0] modulus;
      bit [DATA_WIDTH-1:0] generator;
      bit [DATA_WIDTH-1:0] public_key;
      cipher_pair_type pending_ciphers[$];
      int error_count;

      function new();
         modulus = 2;
         generator = 0;
         public_key = 0;
         error_count = 0;
      endfunction

      function void set_register(csr_index_type index, bit [DATA_WIDTH-1:0] value);
         case (index)
            CSR_MODULUS:    modulus = value;
            CSR_GENERATOR:  generator = value;
            CSR_PUBLIC_KEY: public_key = value;
            default: ;
         endcase
      endfunction

      // square-and-multiply from the lowest exponent bit, 64-bit products
      function void note_request(bit [DATA_WIDTH-1:0] digit, bit [EXP_WIDTH-1:0] exponent);
         bit [63:0] mask, m, gbase, kbase, gacc, kacc, reduced_digit, product;
         bit [EXP_WIDTH-1:0] bits_left;
         cipher_pair_type owed;
         mask = (64'd1 << OPERAND_BITS) - 64'd1;
         m = modulus & mask;
         // a zero modulus wraps at the operand width
         if (m == 0) m = mask + 64'd1;
         gbase = (generator & mask) % m;
         kbase = (public_key & mask) % m;
         gacc = 64'd1 % m;
         kacc = 64'd1 % m;
         bits_left = exponent;
         while (bits_left != 0) begin
            if (bits_left[0]) begin
               gacc = (gacc * gbase) % m;
               kacc = (kacc * kbase) % m;
            end
            gbase = (gbase * gbase) % m;
            kbase = (kbase * kbase) % m;
            bits_left = bits_left >> 1;
         end
         reduced_digit = (digit & mask) % m;
         product = (kacc * reduced_digit) % m;
         owed.first = gacc[DATA_WIDTH-1:0];
         owed.second = product[DATA_WIDTH-1:0];
         pending_ciphers = {pending_ciphers, owed};
      endfunction

      function void check_response(logic [DATA_WIDTH-1:0] first,
                                   logic [DATA_WIDTH-1:0] second);
         cipher_pair_type owed;
         if (pending_ciphers.size() == 0) begin
            $error("cipher result with no request outstanding: first %h second %h",
                   first, second);
            error_count++;
            return;
         end
         owed = pending_ciphers.pop_front();
         if (first !== owed.first) begin
            $error("cipher_first: expected %h, actual %h", owed.first, first);
            error_count++;
         end
         if (second !== owed.second) begin
            $error("cipher_second: expected %h, actual %h", owed.second, second);
            error_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [DATA_WIDTH-1:0] req_message_digit = '0;
   logic [EXP_WIDTH-1:0] req_ephemeral_exponent = '0;
   logic rsp_valid;
   logic [DATA_WIDTH-1:0] rsp_cipher_first;
   logic [DATA_WIDTH-1:0] rsp_cipher_second;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_MODULUS;
   logic [DATA_WIDTH-1:0] csr_wdata = '0;

   cipher_scoreboard sb = new();
   int cycle_count = 0;
   int burst_left = 0;
   bit steady_sender = 1'b0;

   elgamal_encrypt_unit #(
      .MOD_WIDTH(OPERAND_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_message_digit(req_message_digit),
      .req_ephemeral_exponent(req_ephemeral_exponent),
      .rsp_valid(rsp_valid),
      .rsp_cipher_first(rsp_cipher_first),
      .rsp_cipher_second(rsp_cipher_second),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result transfer: one strobe cycle, no back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         sb.check_response(rsp_cipher_first, rsp_cipher_second);
      end
   end

   // leaves csr_we high so back-to-back writes need no second assignment
   task automatic write_register(csr_index_type index, bit [DATA_WIDTH-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(index, value);
   endtask

   task automatic write_config(bit [DATA_WIDTH-1:0] m, bit [DATA_WIDTH-1:0] g,
                               bit [DATA_WIDTH-1:0] k);
      write_register(CSR_MODULUS, m);
      write_register(CSR_GENERATOR, g);
      write_register(CSR_PUBLIC_KEY, k);
      csr_we <= 1'b0;
      csr_wdata <= $urandom;
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (sb.pending_ciphers.size() != 0 || busy !== 1'b0);
   endtask

   // one request transfer, then keep start up for a burst or drop it for a gap or at the end of a phase
   task automatic send_request(bit [DATA_WIDTH-1:0] digit, bit [EXP_WIDTH-1:0] exponent,
                               bit phase_end);
      int gap;
      gap = 0;
      start <= 1'b1;
      req_message_digit <= digit;
      req_ephemeral_exponent <= exponent;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(digit, exponent);
      if (!phase_end && !steady_sender) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, MAX_GAP);
            burst_left = $urandom_range(0, 7);
         end else begin
            burst_left--;
         end
      end
      if (phase_end || gap > 0) begin
         start <= 1'b0;
         req_message_digit <= $urandom;
         req_ephemeral_exponent <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   // base value: mostly reduced, sometimes an extreme or above the modulus
   function automatic bit [DATA_WIDTH-1:0] pick_base(bit [DATA_WIDTH-1:0] m);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return DATA_WIDTH'(1);
         2: return '1;
         3: return $urandom;
         default: return (m == 0) ? $urandom : $urandom % m;
      endcase
   endfunction

   initial begin
      bit [DATA_WIDTH-1:0] m, g, k, digit;
      bit [EXP_WIDTH-1:0] exponent;
      int pick, width, phase_items, sent;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at their reset values
      send_request(32'd0, 32'd0, 1'b0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_request(32'd1, 32'd1, 1'b1);
      wait_idle();

      // modulus one gives zero everywhere, even for a zero exponent
      write_register(CSR_UNUSED, 32'hDEAD_BEEF);
      write_config(32'd1, 32'd5, 32'd7);
      send_request(32'd3, 32'd0, 1'b0);
      send_request(32'd0, 32'd5, 1'b1);
      wait_idle();

      // zero modulus wraps at the operand width
      write_config(32'd0, 32'hFFFF_FFFF, 32'd3);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_request(32'd12345, 32'd0, 1'b0);
      send_request(32'd2, 32'h8000_0000, 1'b1);
      wait_idle();

      // largest 32-bit prime, bases and digit above the modulus
      write_config(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFC);
      send_request(32'hFFFF_FFFA, 32'd1, 1'b0);
      send_request(32'hFFFF_FFFF, 32'd2, 1'b0);
      send_request(32'd0, 32'hFFFF_FFFF, 1'b0);
      send_request(32'hFFFF_FFFA, 32'd0, 1'b1);
      wait_idle();

      // all-ones modulus, zero public key
      write_config(32'hFFFF_FFFF, 32'd2, 32'd0);
      send_request(32'd7, 32'h1234_5678, 1'b0);
      send_request(32'd1, 32'd0, 1'b1);
      wait_idle();

      // small prime group, alternating exponent patterns
      write_config(32'd23, 32'd5, 32'd19);
      send_request(32'd22, 32'd6, 1'b0);
      send_request(32'd22, 32'hAAAA_AAAA, 1'b0);
      send_request(32'h5555_5555, 32'h5555_5555, 1'b1);
      wait_idle();

      // random phases, each with its own group and sender pacing
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) m = $urandom | 32'h8000_0001;
         else if (pick < 40) m = '0;
         else if (pick < 50) m = 32'hFFFF_FFFF;
         else if (pick < 60) m = 32'hFFFF_FFFB;
         else if (pick < 75) m = $urandom_range(2, 1000);
         else if (pick < 80) m = 32'd1;
         else if (pick < 85) m = 32'd2;
         else m = $urandom;
         g = pick_base(m);
         k = pick_base(m);
         write_config(m, g, k);
         steady_sender = ($urandom_range(0, 3) == 0);
         phase_items = $urandom_range(20, 60);
         for (int n = 0; n < phase_items && sent < RANDOM_ITEMS; n++) begin
            // mostly short exponents to keep the run short, a few full width
            pick = $urandom_range(0, 99);
            if (pick < 3) width = 0;
            else if (pick < 73) width = $urandom_range(1, 8);
            else if (pick < 90) width = $urandom_range(9, EXP_WIDTH - 1);
            else width = EXP_WIDTH;
            exponent = EXP_WIDTH'($urandom & ((64'd1 << width) - 64'd1));
            if (m == 0 || $urandom_range(0, 99) < 15) digit = $urandom;
            else digit = $urandom % m;
            sent++;
            send_request(digit, exponent, n == phase_items - 1 || sent == RANDOM_ITEMS);
         end
         wait_idle();
      end

      // watch for stray results after the last one
      repeat (ITEM_WORST_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending_ciphers.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
